>>> hw/rtl/shp_pkg.sv
// ----------------------------------------------------------------------------
// Sponge hash package
// Shared constants, types and permutation functions for the 384-bit sponge
// hash.
// ----------------------------------------------------------------------------
package shp_pkg;

   localparam int RATE_BYTES_DEFAULT = 16;
   localparam int STATE_WORDS        = 12;
   localparam int STATE_BYTES        = 48;
   localparam int BYTE_IDX_W         = 6;
   localparam int ROUNDS_PER_STEP    = 2;
   localparam int PERM_STEPS         = 24 / ROUNDS_PER_STEP;
   localparam int STEP_W             = $clog2(PERM_STEPS);
   localparam int ROUND_W            = 5;
   localparam int QUEUE_DEPTH        = 4;
   localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] ROUND_CONST = 32'h79379E00;
   localparam logic [7:0]  PAD_FIRST   = 8'h80;
   localparam logic [7:0]  PAD_LAST    = 8'h01;

   typedef logic [STATE_WORDS-1:0][31:0] state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } item_type;

   // XOR one byte into the state; byte k sits little-endian in word k/4.
   function automatic state_type xor_byte(state_type s, logic [BYTE_IDX_W-1:0] idx,
                                          logic [7:0] v);
      state_type n;
      n = s;
      for (int w = 0; w < STATE_WORDS; w++) begin
         for (int b = 0; b < 4; b++) begin
            if (idx == BYTE_IDX_W'(w * 4 + b)) begin
               n[w][b*8 +: 8] = s[w][b*8 +: 8] ^ v;
            end
         end
      end
      return n;
   endfunction

   // One round: column SP-box, then swap+constant if r%4==0, half swap if r%4==2.
   function automatic state_type perm_round(state_type s, logic [ROUND_W-1:0] r);
      state_type   n;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] t;
      n = s;
      for (int c = 0; c < 4; c++) begin
         x = {s[c][7:0], s[c][31:8]};
         y = {s[4+c][22:0], s[4+c][31:23]};
         z = s[8+c];
         n[8+c] = x ^ {z[30:0], 1'b0} ^ {(y[29:0] & z[29:0]), 2'b00};
         n[4+c] = y ^ x ^ {(x[30:0] | z[30:0]), 1'b0};
         n[c]   = z ^ y ^ {(x[28:0] & y[28:0]), 3'b000};
      end
      if (r[1:0] == 2'd0) begin
         t    = n[0];
         n[0] = n[1];
         n[1] = t;
         t    = n[2];
         n[2] = n[3];
         n[3] = t;
         n[0] = n[0] ^ ROUND_CONST ^ {{(32-ROUND_W){1'b0}}, r};
      end else if (r[1:0] == 2'd2) begin
         t    = n[0];
         n[0] = n[2];
         n[2] = t;
         t    = n[1];
         n[1] = n[3];
         n[3] = t;
      end
      return n;
   endfunction

endpackage

>>> hw/rtl/shp_if.sv
// ----------------------------------------------------------------------------
// Sponge hash channels
// Valid/ready channels for message items and digest chunks.
// ----------------------------------------------------------------------------
interface shp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, data_byte, has_byte, last, input ready);
   modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface shp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_chunk;
   logic        chunk_last;

   modport source (output valid, digest_chunk, chunk_last, input ready);
   modport sink   (input valid, digest_chunk, chunk_last, output ready);
endinterface

>>> hw/rtl/shp_item_fifo.sv
// ----------------------------------------------------------------------------
// Sponge hash item queue
// Accepts message items and holds them until the engine takes them.
// ----------------------------------------------------------------------------
module shp_item_fifo (
   input  logic             clock,
   input  logic             reset,
   shp_req_if.sink          req_chan,
   output logic             item_valid,
   output shp_pkg::item_type item,
   input  logic             item_pop
);

   shp_pkg::item_type                     mem_ff [shp_pkg::QUEUE_DEPTH];
   logic [shp_pkg::QUEUE_PTR_W-1:0]       head_ff;
   logic [shp_pkg::QUEUE_PTR_W-1:0]       head_in;
   logic [shp_pkg::QUEUE_PTR_W-1:0]       tail_ff;
   logic [shp_pkg::QUEUE_PTR_W-1:0]       tail_in;
   logic [shp_pkg::QUEUE_CNT_W-1:0]       count_ff;
   logic [shp_pkg::QUEUE_CNT_W-1:0]       count_in;
   logic                                  push;
   logic                                  pop;

   assign req_chan.ready = (count_ff != shp_pkg::QUEUE_CNT_W'(shp_pkg::QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign item_valid     = (count_ff != '0);
   assign pop            = item_pop && item_valid;
   assign item           = mem_ff[head_ff];

   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= '{data_byte: req_chan.data_byte,
                              has_byte:  req_chan.has_byte,
                              last:      req_chan.last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> hw/rtl/shp_engine.sv
// ----------------------------------------------------------------------------
// Sponge hash engine
// Absorbs bytes, runs the permutation two rounds per cycle, pads and squeezes
// the digest into a two-chunk output buffer.
// ----------------------------------------------------------------------------
module shp_engine #(
   parameter int RATE_BYTES = shp_pkg::RATE_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  shp_pkg::item_type item,
   output logic             item_pop,
   shp_rsp_if.source        rsp_chan
);

   localparam int POS_W = (RATE_BYTES > 1) ? $clog2(RATE_BYTES) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PAD  = 2'd1;
   localparam logic [1:0] ST_PERM = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   localparam logic [1:0] PH_ABSORB = 2'd0;
   localparam logic [1:0] PH_DIG1   = 2'd1;
   localparam logic [1:0] PH_DIG2   = 2'd2;

   logic [1:0]                    fsm_ff;
   logic [1:0]                    fsm_in;
   logic [1:0]                    phase_ff;
   logic [1:0]                    phase_in;
   logic                          pend_ff;
   logic                          pend_in;
   logic [shp_pkg::STEP_W-1:0]    step_ff;
   logic [shp_pkg::STEP_W-1:0]    step_in;
   logic [POS_W-1:0]              pos_ff;
   logic [POS_W-1:0]              pos_in;
   shp_pkg::state_type            state_ff;
   shp_pkg::state_type            state_in;
   shp_pkg::state_type            absorbed;
   shp_pkg::state_type            padded;
   shp_pkg::state_type            round_a;
   shp_pkg::state_type            round_b;
   logic [3:0][31:0]              buf_ff;
   logic [3:0][31:0]              buf_in;
   logic [1:0]                    cnt_ff;
   logic [1:0]                    cnt_in;
   logic                          final_ff;
   logic                          final_in;
   logic                          block_full;
   logic                          rsp_take;

   assign item_pop   = (fsm_ff == ST_IDLE) && item_valid;
   assign block_full = (pos_ff == POS_W'(RATE_BYTES - 1));
   assign rsp_take   = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.valid        = (cnt_ff != 2'd0);
   assign rsp_chan.digest_chunk = {buf_ff[1], buf_ff[0]};
   assign rsp_chan.chunk_last   = final_ff && (cnt_ff == 2'd1);

   always_comb begin
      absorbed = shp_pkg::xor_byte(state_ff, shp_pkg::BYTE_IDX_W'(pos_ff), item.data_byte);
      padded   = shp_pkg::xor_byte(
                    shp_pkg::xor_byte(state_ff, shp_pkg::BYTE_IDX_W'(pos_ff),
                                      shp_pkg::PAD_FIRST),
                    shp_pkg::BYTE_IDX_W'(RATE_BYTES - 1), shp_pkg::PAD_LAST);
      round_a  = shp_pkg::perm_round(state_ff, {step_ff, 1'b0});
      round_b  = shp_pkg::perm_round(round_a, {step_ff, 1'b1});
   end

   always_comb begin
      fsm_in   = fsm_ff;
      phase_in = phase_ff;
      pend_in  = pend_ff;
      step_in  = step_ff;
      pos_in   = pos_ff;
      state_in = state_ff;
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      final_in = final_ff;

      if (rsp_take) begin
         buf_in[0] = buf_ff[2];
         buf_in[1] = buf_ff[3];
         cnt_in    = cnt_ff - 2'd1;
      end

      unique case (fsm_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (item.has_byte) begin
                  state_in = absorbed;
                  if (block_full) begin
                     pos_in   = '0;
                     phase_in = PH_ABSORB;
                     pend_in  = item.last;
                     step_in  = '0;
                     fsm_in   = ST_PERM;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                     fsm_in = item.last ? ST_PAD : ST_IDLE;
                  end
               end else begin
                  fsm_in = item.last ? ST_PAD : ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            state_in = padded;
            phase_in = PH_DIG1;
            step_in  = '0;
            fsm_in   = ST_PERM;
         end
         ST_PERM: begin
            state_in = round_b;
            step_in  = step_ff + 1'b1;
            if (step_ff == shp_pkg::STEP_W'(shp_pkg::PERM_STEPS - 1)) begin
               if (phase_ff == PH_ABSORB) begin
                  fsm_in  = pend_ff ? ST_PAD : ST_IDLE;
                  pend_in = 1'b0;
               end else begin
                  fsm_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (cnt_ff == 2'd0) begin
               buf_in   = state_ff[3:0];
               cnt_in   = 2'd2;
               final_in = (phase_ff == PH_DIG2);
               if (phase_ff == PH_DIG2) begin
                  state_in = '0;
                  pos_in   = '0;
                  fsm_in   = ST_IDLE;
               end else begin
                  phase_in = PH_DIG2;
                  step_in  = '0;
                  fsm_in   = ST_PERM;
               end
            end
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff   <= ST_IDLE;
         phase_ff <= PH_ABSORB;
         pend_ff  <= 1'b0;
         pos_ff   <= '0;
         state_ff <= '0;
         cnt_ff   <= 2'd0;
         final_ff <= 1'b0;
      end else begin
         fsm_ff   <= fsm_in;
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         pos_ff   <= pos_in;
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         final_ff <= final_in;
      end
   end

endmodule

>>> hw/rtl/sponge_hash_perm384_top.sv
// Each message byte is absorbed from the engine's idle state; a full block then runs the permutation.
// A last item is padded and permuted before its first digest beat, after an absorb
// permutation if its byte fills a block; its last digest beat follows a second permutation.
// Throughput is set by the permutation unit, two rounds per cycle, sharing the state.
// The item queue holds 4 items; the output buffer holds two chunks.
// Synchronous reset clears the state, the byte position, the queue and the output buffer count.
// ----------------------------------------------------------------------------
// Sponge hash top level
// Item queue in front of the absorb and permutation engine.
// ----------------------------------------------------------------------------
module sponge_hash_perm384_top #(
   parameter int RATE_BYTES = shp_pkg::RATE_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   shp_req_if.sink    req_chan,
   shp_rsp_if.source  rsp_chan
);

   logic              item_valid;
   logic              item_pop;
   shp_pkg::item_type item;

   shp_item_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   shp_engine #(
      .RATE_BYTES (RATE_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_chan   (rsp_chan)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("Engine took an item from an empty queue.");

   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !item_pop) |=> item_valid)
      else $error("Queue lost a pushed item.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.chunk_last) |=> !rsp_chan.valid)
      else $error("Output buffer not empty after the final digest beat.");
`endif

endmodule
